FILE: rtl/bcdss_pkg.sv
package bcdss_pkg;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_BLANK = 2'd2;

    localparam logic [3:0] MINUS_CODE = 4'hF;
    localparam logic [7:0] SEG_MINUS  = 8'b0100_0000;
    localparam logic [7:0] SEG_OFF    = 8'b0000_0000;
    localparam logic [3:0] EN_ALL_OFF = 4'hF;

    // status and result of the decimal converter
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] digits;
        logic [1:0]  lead;
    } conv_stat_t;

    function automatic logic [7:0] seg_decode(input logic [3:0] code);
        logic [7:0] seg;
        unique case (code)
            4'd0:       seg = 8'b0011_1111;
            4'd1:       seg = 8'b0000_0110;
            4'd2:       seg = 8'b0101_1011;
            4'd3:       seg = 8'b0100_1111;
            4'd4:       seg = 8'b0110_0110;
            4'd5:       seg = 8'b0110_1101;
            4'd6:       seg = 8'b0111_1101;
            4'd7:       seg = 8'b0000_0111;
            4'd8:       seg = 8'b0111_1111;
            4'd9:       seg = 8'b0110_1111;
            MINUS_CODE: seg = SEG_MINUS;
            default:    seg = SEG_OFF;
        endcase
        return seg;
    endfunction

endpackage

FILE: rtl/bcdss_dabble.sv
module bcdss_dabble
    import bcdss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] value,
    output conv_stat_t  stat
);

    localparam int          NBITS    = 16;
    localparam logic [3:0]  LAST_CNT = 4'(NBITS - 1);

    logic        run_reg;
    logic        fin_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] mag_reg;
    logic [15:0] bcd_reg;
    logic        neg_reg;

    logic [15:0] bcd_adj;
    logic [15:0] mag_in;
    logic [3:0]  thou;
    logic        z0;
    logic        z1;
    logic        z2;

    function automatic logic [3:0] add3(input logic [3:0] n);
        return (n >= 4'd5) ? 4'(n + 4'd3) : n;
    endfunction

    assign mag_in = value[15] ? 16'(~value + 16'd1) : value;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            bcd_adj[k*4 +: 4] = add3(bcd_reg[k*4 +: 4]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= 4'(cnt_reg + 4'd1);
                if (cnt_reg == LAST_CNT)
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    // shift-add-3, one magnitude bit per cycle; carries out of the
    // thousands digit are dropped, which leaves the value modulo 10000
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= mag_in;
            neg_reg <= value[15];
            bcd_reg <= '0;
        end
        else if (run_reg)
        begin
            bcd_reg <= {bcd_adj[14:0], mag_reg[15]};
            mag_reg <= {mag_reg[14:0], 1'b0};
        end
    end

    assign thou = neg_reg ? MINUS_CODE : bcd_reg[15:12];
    assign z0   = (thou == 4'd0);
    assign z1   = (bcd_reg[11:8] == 4'd0);
    assign z2   = (bcd_reg[7:4] == 4'd0);

    assign stat.busy   = run_reg | fin_reg;
    assign stat.done   = fin_reg;
    assign stat.digits = {bcd_reg[3:0], bcd_reg[7:4], bcd_reg[11:8], thou};
    assign stat.lead   = !z0 ? 2'd0 : (!z1 ? 2'd1 : (!z2 ? 2'd2 : 2'd3));

endmodule

FILE: rtl/bcd_seven_segment_scan_driver_unit.sv
// Four-digit multiplexed seven-segment driver. tuser selects the action:
// load converts the signed tdata value (magnitude modulo 10000, minus sign in
// the thousands place) with a shift-add-3 converter that takes one magnitude
// bit per cycle, and a load result enters the output register when it is done;
// scan ticks and blank items produce their result in the cycle after transfer.
// One item is in work at a time, and the input is held off while a result
// sits unaccepted in the output register. Position 0 is the thousands digit,
// digit_enable is active low, and blank_leading_zeros is read at each tick.
module bcd_seven_segment_scan_driver_unit
    import bcdss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] segments, [11:8] digit_enable,
                                   // [27:12] digit_code, [31:28] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    conv_stat_t  conv;

    logic        blz_reg;
    logic [15:0] store_reg;
    logic [1:0]  first_reg;
    logic [1:0]  pos_reg;
    logic        active_reg;
    logic        mval_reg;
    logic [7:0]  seg_reg;
    logic [3:0]  en_reg;
    logic [15:0] code_reg;

    logic        take;
    logic        is_load;
    logic        is_tick;
    logic [1:0]  start_pos;
    logic [1:0]  pos_next;
    logic [3:0]  tick_digit;

    assign cfg_ready = 1'b1;
    assign s_tready  = !conv.busy && (!mval_reg || m_tready);
    assign take      = s_tvalid && s_tready;
    assign is_load   = (s_tuser == ACT_LOAD);
    assign is_tick   = (s_tuser == ACT_TICK);

    assign start_pos = blz_reg ? first_reg : 2'd0;

    always_comb
    begin
        if (!active_reg || pos_reg == 2'd3 || pos_reg < start_pos)
        begin
            pos_next = start_pos;
        end
        else
        begin
            pos_next = 2'(pos_reg + 2'd1);
        end
    end

    always_comb
    begin
        unique case (pos_next)
            2'd0:    tick_digit = store_reg[3:0];
            2'd1:    tick_digit = store_reg[7:4];
            2'd2:    tick_digit = store_reg[11:8];
            default: tick_digit = store_reg[15:12];
        endcase
    end

    bcdss_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (take && is_load),
        .value (s_tdata),
        .stat  (conv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blz_reg    <= 1'b0;
            store_reg  <= '0;
            first_reg  <= '0;
            pos_reg    <= '0;
            active_reg <= 1'b0;
            mval_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                blz_reg <= cfg_data;
            end
            if (conv.done)
            begin
                store_reg <= conv.digits;
                first_reg <= conv.lead;
            end
            if (take)
            begin
                active_reg <= is_tick;
                if (is_tick)
                begin
                    pos_reg <= pos_next;
                end
            end
            // result for a tick or blank lands now; a load waits for the converter
            priority if (conv.done || (take && !is_load))
            begin
                mval_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                mval_reg <= 1'b0;
            end
            else
            begin
                mval_reg <= mval_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (conv.done)
        begin
            seg_reg  <= SEG_OFF;
            en_reg   <= EN_ALL_OFF;
            code_reg <= conv.digits;
        end
        else if (take && !is_load)
        begin
            code_reg <= store_reg;
            if (is_tick)
            begin
                seg_reg <= seg_decode(tick_digit);
                en_reg  <= EN_ALL_OFF ^ (4'd1 << pos_next);
            end
            else
            begin
                seg_reg <= SEG_OFF;
                en_reg  <= EN_ALL_OFF;
            end
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = {4'd0, code_reg, en_reg, seg_reg};

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        conv.busy |-> !s_tready)
        else $error("input accepted while the converter is busy");

    a_done_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        conv.done |-> !mval_reg)
        else $error("conversion finished with the output register occupied");

    a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        conv.done |=> (mval_reg && en_reg == EN_ALL_OFF && code_reg == store_reg))
        else $error("load result missing or wrong after conversion");

    a_one_digit_lit: assert property (@(posedge clk) disable iff (!rst_n)
        mval_reg |-> $onehot0(~en_reg))
        else $error("more than one digit enabled");

    a_tick_activates: assert property (@(posedge clk) disable iff (!rst_n)
        (take && is_tick) |=> (active_reg && en_reg != EN_ALL_OFF))
        else $error("scan tick did not light a digit");

endmodule

FILE: test/testbench.sv
module testbench;
    import bcdss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_SPARE   = 2'd3;   // unused code, acts as blank
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [1:0]  act;
        logic [15:0] val;
    } display_cmd_t;

    // same layout as m_tdata
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] code;
        logic [3:0]  en;
        logic [7:0]  seg;
    } display_frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [15:0] value
    logic [1:0]  s_tuser = '0;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [7:0] segments, [11:8] digit_enable, [27:12] digit_code
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    display_cmd_t   cmd_q[$];
    display_frame_t frame_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;

    // display state kept alongside the block
    logic [15:0] disp_digits = '0;
    logic [1:0]  disp_pos = '0;
    logic [1:0]  disp_first = '0;
    logic        disp_scanning = 1'b0;
    logic        disp_blank_lz = 1'b0;

    bcd_seven_segment_scan_driver_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] segments_of(input logic [3:0] code);
        case (code)
            4'd0:       return 8'h3F;
            4'd1:       return 8'h06;
            4'd2:       return 8'h5B;
            4'd3:       return 8'h4F;
            4'd4:       return 8'h66;
            4'd5:       return 8'h6D;
            4'd6:       return 8'h7D;
            4'd7:       return 8'h07;
            4'd8:       return 8'h7F;
            4'd9:       return 8'h6F;
            MINUS_CODE: return SEG_MINUS;
            default:    return SEG_OFF;
        endcase
    endfunction

    // Apply one accepted item to the display state and queue the frame it shows.
    function void advance_display(input logic [1:0] act, input logic [15:0] val);
        logic           neg;
        int unsigned    mag;
        logic [3:0]     thou, hund, tens, units;
        logic [1:0]     start;
        display_frame_t f;
        f.pad  = 4'h0;
        f.seg  = SEG_OFF;
        f.en   = EN_ALL_OFF;
        start  = disp_blank_lz ? disp_first : 2'd0;
        if (act == ACT_LOAD) begin
            neg   = val[15];
            mag   = neg ? (32'h10000 - {16'h0, val}) : {16'h0, val};
            mag   = mag % 10000;
            thou  = neg ? MINUS_CODE : 4'(mag / 1000);
            hund  = 4'((mag / 100) % 10);
            tens  = 4'((mag / 10) % 10);
            units = 4'(mag % 10);
            disp_digits = {units, tens, hund, thou};
            if (thou != 4'd0)
                disp_first = 2'd0;
            else if (hund != 4'd0)
                disp_first = 2'd1;
            else if (tens != 4'd0)
                disp_first = 2'd2;
            else
                disp_first = 2'd3;
            disp_scanning = 1'b0;
        end else if (act == ACT_TICK) begin
            // restart on first tick, wrap, or when the start moved past us
            if (!disp_scanning || disp_pos == 2'd3 || disp_pos < start)
                disp_pos = start;
            else
                disp_pos = disp_pos + 2'd1;
            disp_scanning = 1'b1;
            f.seg = segments_of(disp_digits[disp_pos*4 +: 4]);
            f.en  = 4'hF ^ (4'd1 << disp_pos);
        end else begin
            disp_scanning = 1'b0;
        end
        f.code = disp_digits;
        frame_q.push_back(f);
    endfunction

    // input side
    always @(posedge clk or negedge rst_n) begin
        display_cmd_t nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                advance_display(s_tuser, s_tdata);
            // hold an item that has not transferred yet
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.val;
                    s_tuser  <= nxt.act;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge clk or negedge rst_n) begin
        display_frame_t got;
        display_frame_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (frame_q.size() == 0) begin
                    if (error_count < 10)
                        $display("unexpected frame: seg %h en %h code %h",
                                 got.seg, got.en, got.code);
                    error_count++;
                end else begin
                    want = frame_q.pop_front();
                    if (got.seg !== want.seg || got.en !== want.en ||
                        got.code !== want.code || got.pad !== want.pad) begin
                        if (error_count < 10)
                            $display("frame mismatch: seg %h/%h en %h/%h code %h/%h pad %h/%h",
                                     want.seg, got.seg, want.en, got.en,
                                     want.code, got.code, want.pad, got.pad);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_cmd(input logic [1:0] act, input logic [15:0] val);
        display_cmd_t c;
        c.act = act;
        c.val = val;
        cmd_q.push_back(c);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (cmd_q.size() != 0 || s_tvalid || frame_q.size() != 0);
    endtask

    task automatic write_blank_lz(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk);
        while (!cfg_ready);
        disp_blank_lz = v;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_value();
        int unsigned mag;
        logic [15:0] v;
        case ($urandom_range(3))
            0: v = 16'($urandom);
            1: begin
                mag = $urandom_range(99);
                v = $urandom_range(1) ? 16'(-mag) : 16'(mag);
            end
            2: begin
                mag = $urandom_range(9999);
                v = $urandom_range(1) ? 16'(-mag) : 16'(mag);
            end
            default: begin
                case ($urandom_range(6))
                    0: v = 16'h0000;
                    1: v = 16'h8000;
                    2: v = 16'h7FFF;
                    3: v = 16'hFFFF;
                    4: v = 16'(10000);
                    5: v = 16'(-10000);
                    default: v = 16'(20000);
                endcase
            end
        endcase
        return v;
    endfunction

    // mostly load-then-scan runs, with loose ticks and blanks mixed in
    task automatic add_random_cmds(input int n);
        int cnt;
        int k;
        int r;
        cnt = 0;
        while (cnt < n) begin
            r = $urandom_range(99);
            if (r < 70) begin
                push_cmd(ACT_LOAD, pick_value());
                k = $urandom_range(6, 1);
                repeat (k) push_cmd(ACT_TICK, 16'($urandom));
                cnt += k + 1;
            end else if (r < 85) begin
                k = $urandom_range(3, 1);
                repeat (k) push_cmd(ACT_TICK, 16'($urandom));
                cnt += k;
            end else begin
                push_cmd($urandom_range(1) ? ACT_BLANK : ACT_SPARE, 16'($urandom));
                cnt++;
            end
        end
    endtask

    initial begin
        int phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, wrap, blank and spare action
        push_cmd(ACT_TICK, 16'h0000);
        push_cmd(ACT_LOAD, 16'h0000);
        push_cmd(ACT_TICK, 16'hFFFF);
        push_cmd(ACT_TICK, 16'h0000);
        push_cmd(ACT_LOAD, 16'h7FFF);
        repeat (5) push_cmd(ACT_TICK, 16'h0000);
        push_cmd(ACT_LOAD, 16'h8000);
        push_cmd(ACT_TICK, 16'h0000);
        push_cmd(ACT_BLANK, 16'hFFFF);
        push_cmd(ACT_TICK, 16'h0000);
        push_cmd(ACT_SPARE, 16'hA5A5);
        push_cmd(ACT_LOAD, 16'hFFFF);
        push_cmd(ACT_TICK, 16'h0000);
        push_cmd(ACT_LOAD, 16'(9999));
        push_cmd(ACT_LOAD, 16'(10000));
        push_cmd(ACT_LOAD, 16'(-9999));
        push_cmd(ACT_LOAD, 16'(5));
        push_cmd(ACT_TICK, 16'h0000);
        push_cmd(ACT_TICK, 16'h0000);
        wait_drained();

        // turn on blanking mid-scan: position now lies below the start
        write_blank_lz(1'b1);
        push_cmd(ACT_TICK, 16'h0000);
        push_cmd(ACT_TICK, 16'h0000);
        push_cmd(ACT_LOAD, 16'h0000);
        push_cmd(ACT_TICK, 16'h0000);
        push_cmd(ACT_LOAD, 16'(120));
        repeat (4) push_cmd(ACT_TICK, 16'h0000);
        wait_drained();
        write_blank_lz(1'b0);
        push_cmd(ACT_TICK, 16'h0000);
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            write_blank_lz(phase[0]);
            add_random_cmds(60);
            // hold the sender until every frame is back, then set blanking at random
            wait_drained();
            write_blank_lz(1'($urandom_range(1)));
            add_random_cmds(65);
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(negedge clk);
        if (error_count == 0 && frame_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
